// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by record_delimiter_splitter_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define RDS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define RDS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- hw/rtl/rds_pkg.sv -----
// shared types and constants of the record delimiter splitter
package rds_pkg;

  localparam int unsigned DELIM_W   = 64;
  localparam int unsigned DLEN_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned MAX_DELIM = 8;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_EOF   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 1'd1;

  localparam logic CAUSE_DELIM = 1'b0;
  localparam logic CAUSE_EOF   = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic       end_cause;
    logic       last;
  } out_word_t;

endpackage

// ----- hw/rtl/rds_if.sv -----
// valid/ready channel interfaces for input and result words
interface rds_in_if;
  logic              valid;
  logic              ready;
  rds_pkg::in_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

interface rds_out_if;
  logic               valid;
  logic               ready;
  rds_pkg::out_word_t word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

// ----- hw/rtl/rds_cell.sv -----
// one window cell: holds a byte, shifts from its neighbor, compares the incoming byte
module rds_cell (
  input  logic       clk_i,
  input  logic       shift_en_i,
  input  logic [7:0] shift_in_i,
  input  logic [7:0] want_i,
  output logic [7:0] byte_o,
  output logic       match_o
);

  logic [7:0] byte_q;

  // compare the value the cell holds after this shift
  assign match_o = (shift_in_i == want_i);
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      byte_q <= shift_in_i;
    end
  end

endmodule

// ----- hw/rtl/record_delimiter_splitter_unit.sv -----
// top level of the record delimiter splitter
// usage:
// - in_i carries one word per handshake: op (start record, data byte, end of file)
//   and data_byte; out_o carries result words: out_byte, is_end, end_cause, last
// - cfg_we_i/cfg_idx_i/cfg_data_i write the delimiter bytes (index 0) and the
//   delimiter length (index 1); write only while the block is idle
// - the window is a row of cells; cell 0 takes the newest byte, each data word
//   of an open record shifts the row by one; each cell compares its next byte
//   with its delimiter byte, so a match is known in the cycle the byte arrives
// flow:
// - start and data words give at most one result, registered in the next cycle;
//   a new word is taken every cycle unless a flush runs or a result is stalled
// - end of file inside an open record drains the window, one result per cycle
//   while the result slot is free, with in_i held off until the end word is loaded
// reset: record closed, window empty, end of file not seen, config zero
// stall: the result register holds while out_o.ready is low; in_i.ready
//   follows the result register, so nothing is lost or repeated
`include "assert_macros.svh"

module record_delimiter_splitter_unit #(
  parameter int unsigned WINDOW_BYTES = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [rds_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [rds_pkg::DELIM_W-1:0]           cfg_data_i,
  rds_in_if.sink                                in_i,
  rds_out_if.source                             out_o
);

  localparam int unsigned FillW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned IdxW  = (WINDOW_BYTES > 1) ? $clog2(WINDOW_BYTES) : 1;

  // sequencer states
  localparam logic [0:0] ST_RUN   = 1'b0;
  localparam logic [0:0] ST_FLUSH = 1'b1;

  // config registers
  logic [rds_pkg::DELIM_W-1:0] delim_q;
  logic [rds_pkg::DLEN_W-1:0]  dlen_q;

  // control state
  logic [0:0]       state_q, state_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             ended_q, ended_d;
  logic             file_done_q, file_done_d;
  logic             out_valid_q, out_valid_d;
  rds_pkg::out_word_t out_q, out_d;

  // cell row
  logic [7:0]              delim_b   [rds_pkg::MAX_DELIM];
  logic [7:0]              cell_byte [WINDOW_BYTES];
  logic [7:0]              cell_next [WINDOW_BYTES];
  logic [7:0]              cell_want [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] cell_match;
  logic [WINDOW_BYTES-1:0] cell_used;
  logic                    shift_en;

  logic [rds_pkg::DLEN_W-1:0] dlen_c;
  logic [rds_pkg::DLEN_W-1:0] need;
  logic [rds_pkg::DLEN_W-1:0] fill_p1;
  logic [FillW-1:0]           fill_m1;
  logic                       match_all;
  logic                       slot_free;
  logic                       in_ready;
  logic                       accept;

  // clamp the delimiter length to the window
  assign dlen_c = (dlen_q > rds_pkg::DLEN_W'(WINDOW_BYTES)) ?
                  rds_pkg::DLEN_W'(WINDOW_BYTES) : dlen_q;
  assign need    = (dlen_c == '0) ? rds_pkg::DLEN_W'(1) : dlen_c;
  assign fill_p1 = rds_pkg::DLEN_W'(fill_q) + rds_pkg::DLEN_W'(1);
  assign fill_m1 = fill_q - FillW'(1);

  for (genvar b = 0; b < rds_pkg::MAX_DELIM; b++) begin : g_delim
    assign delim_b[b] = delim_q[8*b +: 8];
  end

  // cell j holds the j-th newest byte; after a push the oldest of the
  // delimiter-long window sits in cell dlen-1, so cell j wants byte dlen-1-j
  for (genvar j = 0; j < WINDOW_BYTES; j++) begin : g_cell
    logic [rds_pkg::DLEN_W-1:0] want_idx;

    assign want_idx     = dlen_c - rds_pkg::DLEN_W'(j) - rds_pkg::DLEN_W'(1);
    assign cell_want[j] = delim_b[want_idx[2:0]];
    assign cell_used[j] = (rds_pkg::DLEN_W'(j) < dlen_c);

    if (j == 0) begin : g_head
      assign cell_next[j] = in_i.word.data_byte;
    end else begin : g_link
      assign cell_next[j] = cell_byte[j-1];
    end

    rds_cell u_cell (
      .clk_i      (clk_i),
      .shift_en_i (shift_en),
      .shift_in_i (cell_next[j]),
      .want_i     (cell_want[j]),
      .byte_o     (cell_byte[j]),
      .match_o    (cell_match[j])
    );
  end

  assign match_all = &(cell_match | ~cell_used);

  // handshake: take a word in run state whenever the result slot is free or draining
  assign slot_free   = !out_valid_q || out_o.ready;
  assign in_ready    = (state_q == ST_RUN) && slot_free;
  assign accept      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.word  = out_q;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    ended_d     = ended_q;
    file_done_d = file_done_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d       = out_q;
    shift_en    = 1'b0;

    if (accept) begin
      case (in_i.word.op)
        rds_pkg::OP_START: begin
          fill_d = '0;
          if (file_done_q) begin
            ended_d     = 1'b1;
            out_valid_d = 1'b1;
            out_d       = '{out_byte: 8'd0, is_end: 1'b1,
                            end_cause: rds_pkg::CAUSE_EOF, last: 1'b1};
          end else begin
            ended_d = 1'b0;
          end
        end
        rds_pkg::OP_DATA: begin
          if (!ended_q && !file_done_q && (fill_q < FillW'(WINDOW_BYTES))) begin
            shift_en = 1'b1;
            if ((dlen_c != '0) && (fill_p1 == dlen_c) && match_all) begin
              // delimiter seen: drop it and close the record
              fill_d      = '0;
              ended_d     = 1'b1;
              out_valid_d = 1'b1;
              out_d       = '{out_byte: 8'd0, is_end: 1'b1,
                              end_cause: rds_pkg::CAUSE_DELIM, last: 1'b1};
            end else if (fill_p1 >= need) begin
              // oldest byte leaves, fill count unchanged
              out_valid_d = 1'b1;
              out_d       = '{out_byte: cell_next[fill_q[IdxW-1:0]], is_end: 1'b0,
                              end_cause: rds_pkg::CAUSE_DELIM, last: 1'b1};
            end else begin
              fill_d = fill_q + FillW'(1);
            end
          end
        end
        rds_pkg::OP_EOF: begin
          if (!file_done_q) begin
            file_done_d = 1'b1;
            if (!ended_q) begin
              state_d = ST_FLUSH;
            end
          end
        end
        default: begin
        end
      endcase
    end else if ((state_q == ST_FLUSH) && slot_free) begin
      out_valid_d = 1'b1;
      if (fill_q != '0) begin
        fill_d = fill_m1;
        out_d  = '{out_byte: cell_byte[fill_m1[IdxW-1:0]], is_end: 1'b0,
                   end_cause: rds_pkg::CAUSE_DELIM, last: 1'b0};
      end else begin
        ended_d = 1'b1;
        state_d = ST_RUN;
        out_d   = '{out_byte: 8'd0, is_end: 1'b1,
                    end_cause: rds_pkg::CAUSE_EOF, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q     <= '0;
      dlen_q      <= '0;
      state_q     <= ST_RUN;
      fill_q      <= '0;
      ended_q     <= 1'b1;
      file_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == rds_pkg::CFG_DELIM_BYTES)) begin
        delim_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_idx_i == rds_pkg::CFG_DELIM_LEN)) begin
        dlen_q <= cfg_data_i[rds_pkg::DLEN_W-1:0];
      end
      state_q     <= state_d;
      fill_q      <= fill_d;
      ended_q     <= ended_d;
      file_done_q <= file_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // window never holds a full row between words
  `RDS_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q < FillW'(WINDOW_BYTES))
  // no new word is taken while the window drains
  `RDS_ASSERT_NEVER(a_no_take_in_flush, clk_i, rst_ni,
                    (state_q == ST_FLUSH) && in_i.ready)
  // an end word is always the final result of its input word
  `RDS_ASSERT_NEVER(a_end_is_last, clk_i, rst_ni,
                    out_o.valid && out_o.word.is_end && !out_o.word.last)

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench of record_delimiter_splitter_unit with a built-in record splitter model
module testbench;

  localparam int unsigned WINDOW_BYTES = 8;
  // op code the block must ignore
  localparam logic [1:0] OP_UNDEF = 2'd3;
  // quiet cycles after the last result before a register write
  localparam int unsigned IDLE_GAP = 16;
  // cycles without any handshake before the run is given up
  localparam int unsigned STALL_LIMIT = 2000;
  // least number of words of random stimulus per segment
  localparam int unsigned SEG_WORDS = 24;
  localparam int unsigned NUM_SEGS = 8;

  // clock, reset and the register write port
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rds_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [rds_pkg::DELIM_W-1:0] cfg_data_i = '0;

  // channel drive, known from time zero
  logic in_valid = 1'b0;
  rds_pkg::in_word_t in_word = '0;
  logic out_ready = 1'b0;

  rds_in_if in_ch ();
  rds_out_if out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.word = in_word;
  assign out_ch.ready = out_ready;

  record_delimiter_splitter_unit #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i(in_ch),
    .out_o(out_ch)
  );

  always #10 clk_i = ~clk_i;

  // words waiting to be sent and results still owed by the block
  rds_pkg::in_word_t pending_words[$];
  rds_pkg::out_word_t expected_results[$];

  // percent of cycles the sender idles and the receiver stalls
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned seg_words = 0;

  // splitter model: register copies and window state
  logic [rds_pkg::DELIM_W-1:0] delim_bytes = '0;
  logic [rds_pkg::DLEN_W-1:0] delim_len = '0;
  logic [7:0] win_bytes [WINDOW_BYTES];
  int unsigned fill_cnt = 0;
  logic [2:0] rd_ptr = '0;
  logic [2:0] wr_ptr = '0;
  logic rec_closed = 1'b1;
  logic eof_seen = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch at result %0d: %s", $time, result_count, msg);
    mismatch_count++;
  endtask

  // oldest window byte leaves as a text result
  function automatic void emit_oldest();
    rds_pkg::out_word_t r;
    r = '{out_byte: win_bytes[rd_ptr], is_end: 1'b0, end_cause: rds_pkg::CAUSE_DELIM,
          last: 1'b0};
    expected_results.push_back(r);
    rd_ptr = rd_ptr + 3'd1;
    fill_cnt--;
  endfunction

  function automatic void emit_end(input logic cause);
    rds_pkg::out_word_t r;
    r = '{out_byte: 8'h00, is_end: 1'b1, end_cause: cause, last: 1'b0};
    expected_results.push_back(r);
  endfunction

  function automatic void clear_window();
    fill_cnt = 0;
    rd_ptr = '0;
    wr_ptr = '0;
  endfunction

  // works out the results of one accepted word and queues them
  function automatic void split_word(input rds_pkg::in_word_t w);
    int unsigned dlen;
    int unsigned need;
    int unsigned first;
    logic hit;
    first = expected_results.size();
    // a length above the window is clamped
    dlen = (delim_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(delim_len);
    need = (dlen > 0) ? dlen : 1;
    case (w.op)
      rds_pkg::OP_START: begin
        // buffered bytes of an open record are thrown away
        clear_window();
        if (eof_seen) begin
          rec_closed = 1'b1;
          emit_end(rds_pkg::CAUSE_EOF);
        end else begin
          rec_closed = 1'b0;
        end
      end
      rds_pkg::OP_DATA: begin
        if (!rec_closed && !eof_seen && fill_cnt < WINDOW_BYTES) begin
          win_bytes[wr_ptr] = w.data_byte;
          wr_ptr = wr_ptr + 3'd1;
          fill_cnt++;
          // compare only when the window holds exactly the delimiter length
          if (dlen > 0 && fill_cnt == dlen) begin
            hit = 1'b1;
            for (int unsigned i = 0; i < dlen; i++) begin
              if (win_bytes[3'(rd_ptr + i)] != delim_bytes[8*i +: 8]) hit = 1'b0;
            end
            if (hit) begin
              clear_window();
              rec_closed = 1'b1;
              emit_end(rds_pkg::CAUSE_DELIM);
            end
          end
          if (!rec_closed && fill_cnt >= need) emit_oldest();
        end
      end
      rds_pkg::OP_EOF: begin
        if (!eof_seen) begin
          eof_seen = 1'b1;
          // an open record is flushed byte by byte, then closed
          if (!rec_closed) begin
            while (fill_cnt > 0) emit_oldest();
            clear_window();
            rec_closed = 1'b1;
            emit_end(rds_pkg::CAUSE_EOF);
          end
        end
      end
      default: ;
    endcase
    if (expected_results.size() > first) begin
      expected_results[expected_results.size()-1].last = 1'b1;
    end
  endfunction

  // driver: one word per handshake, valid held high across back-to-back words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_word <= '0;
    end else begin
      if (in_valid && in_ch.ready) split_word(in_word);
      if (!in_valid || in_ch.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: each result against the oldest expectation
  always @(posedge clk_i) begin
    rds_pkg::out_word_t want;
    rds_pkg::out_word_t got;
    if (rst_ni && out_ch.valid && out_ready) begin
      got = out_ch.word;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %h end %b cause %b last %b",
                                  got.out_byte, got.is_end, got.end_cause, got.last));
      end else begin
        want = expected_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.is_end !== want.is_end)
          report_mismatch($sformatf("is_end %b, want %b", got.is_end, want.is_end));
        if (got.end_cause !== want.end_cause)
          report_mismatch($sformatf("end_cause %b, want %b", got.end_cause, want.end_cause));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      end
      result_count++;
    end
  end

  // watchdog: counts cycles with work outstanding and no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ch.ready) || (out_ch.valid && out_ready) ||
        (pending_words.size() == 0 && !in_valid && expected_results.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, expected_results.size());
      $display("** record_delimiter_splitter_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [7:0] b);
    rds_pkg::in_word_t w;
    w.op = op;
    w.data_byte = b;
    pending_words.push_back(w);
    seg_words++;
  endtask

  // everything sent, every result seen, then room for a silent drain
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // writes both registers; only called while the block is idle
  task automatic set_delimiter(input logic [rds_pkg::DELIM_W-1:0] bytes,
                               input logic [rds_pkg::DLEN_W-1:0] len);
    logic [rds_pkg::DELIM_W-1:0] len_word;
    // upper bits of the length write carry noise
    len_word = {$urandom(), $urandom()};
    len_word[rds_pkg::DLEN_W-1:0] = len;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= rds_pkg::CFG_DELIM_BYTES;
    cfg_data_i <= bytes;
    @(posedge clk_i);
    cfg_idx_i <= rds_pkg::CFG_DELIM_LEN;
    cfg_data_i <= len_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    delim_bytes = bytes;
    delim_len = len;
  endtask

  // one record with random text leaning on delimiter bytes, ended in various ways
  task automatic queue_record();
    int unsigned dl;
    int unsigned body;
    int unsigned cut;
    logic [7:0] b;
    dl = (delim_len > WINDOW_BYTES) ? WINDOW_BYTES : int'(delim_len);
    push_word(rds_pkg::OP_START, 8'($urandom()));
    body = $urandom_range(12);
    repeat (body) begin
      if (dl > 0 && $urandom_range(2) == 0) b = delim_bytes[8*$urandom_range(dl-1) +: 8];
      else b = 8'($urandom());
      push_word(rds_pkg::OP_DATA, b);
    end
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: begin
        // full delimiter
        for (int unsigned i = 0; i < dl; i++) push_word(rds_pkg::OP_DATA, delim_bytes[8*i +: 8]);
        if ($urandom_range(3) == 0) push_word(rds_pkg::OP_DATA, 8'($urandom()));
      end
      6, 7: begin
        // near miss: delimiter prefix then a stray byte
        if (dl > 0) begin
          cut = $urandom_range(dl-1);
          for (int unsigned i = 0; i < cut; i++)
            push_word(rds_pkg::OP_DATA, delim_bytes[8*i +: 8]);
        end
        push_word(rds_pkg::OP_DATA, 8'($urandom()));
      end
      8: push_word(OP_UNDEF, 8'($urandom()));
      default: ;
    endcase
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: no delimiter, each byte of an open record passes straight through
    push_word(rds_pkg::OP_DATA, 8'hFF);
    push_word(OP_UNDEF, 8'hA5);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'hFF);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h80);
    wait_idle();

    // two byte delimiter, match and near miss, data while closed is dropped
    set_delimiter(64'h0A0D, 4'd2);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h41);
    push_word(rds_pkg::OP_DATA, 8'h0D);
    push_word(rds_pkg::OP_DATA, 8'h0A);
    push_word(rds_pkg::OP_DATA, 8'h42);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h0D);
    push_word(rds_pkg::OP_DATA, 8'h0D);
    push_word(rds_pkg::OP_DATA, 8'h0A);
    wait_idle();

    // length above the window is clamped to eight; leave the record open with a backlog
    set_delimiter('1, 4'd15);
    push_word(rds_pkg::OP_START, 8'h00);
    repeat (7) push_word(rds_pkg::OP_DATA, 8'hFF);
    push_word(rds_pkg::OP_DATA, 8'hFE);
    repeat (8) push_word(rds_pkg::OP_DATA, 8'hFF);
    push_word(rds_pkg::OP_START, 8'h00);
    repeat (5) push_word(rds_pkg::OP_DATA, 8'hFF);
    wait_idle();

    // shorter delimiter inside an open record: backlog stays, one byte out per byte in
    set_delimiter(64'h0, 4'd1);
    push_word(rds_pkg::OP_DATA, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h7F);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h00);
    wait_idle();

    // random segments, each with its own delimiter and handshake pressure
    for (int unsigned seg = 0; seg < NUM_SEGS; seg++) begin
      case (seg)
        0: set_delimiter(64'h0, 4'd1);
        1: set_delimiter('1, 4'd8);
        2: set_delimiter({$urandom(), $urandom()}, 4'd2);
        3: set_delimiter({$urandom(), $urandom()}, 4'd0);
        4: set_delimiter({$urandom(), $urandom()}, 4'd15);
        5: set_delimiter({$urandom(), $urandom()}, 4'd3);
        6: set_delimiter({$urandom(), $urandom()}, 4'($urandom_range(15)));
        default: set_delimiter({$urandom(), $urandom()}, 4'd1);
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 55; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 55; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      seg_words = 0;
      while (seg_words < SEG_WORDS) queue_record();
      wait_idle();
    end

    // seven byte backlog flushed at end of file, then everything after end of file
    recv_stall_pct = 55;
    send_idle_pct = 0;
    set_delimiter(64'h8877_6655_4433_2211, 4'd8);
    push_word(rds_pkg::OP_START, 8'h00);
    for (int unsigned i = 0; i < 9; i++) push_word(rds_pkg::OP_DATA, 8'(8'hC0 + i));
    push_word(rds_pkg::OP_EOF, 8'h00);
    push_word(rds_pkg::OP_EOF, 8'hFF);
    push_word(rds_pkg::OP_START, 8'h00);
    push_word(rds_pkg::OP_DATA, 8'h55);
    push_word(OP_UNDEF, 8'h00);
    repeat (16) push_word(2'($urandom_range(3)), 8'($urandom()));

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** record_delimiter_splitter_unit: PASSED **");
    end else begin
      $display("** record_delimiter_splitter_unit: FAILED **");
    end
    $finish;
  end

endmodule
